[hw/rtl/lzcf_pkg.sv]
// Shared types, codes and helpers of the copy/fill stream decoder.
// Used by the decoder control and the top level.
package lzcf_pkg;

    localparam int HISTORY_BYTES_DEF = 65536;
    localparam int WPOS_W            = 17;

    typedef enum logic [1:0] {
        REQ_PUSH    = 2'd0,
        REQ_PULL    = 2'd1,
        REQ_RESTART = 2'd2,
        REQ_NOP     = 2'd3
    } lzcf_req_t;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_SRC   = 3'd1;
    localparam logic [2:0] ERR_FULL      = 3'd2;
    localparam logic [2:0] ERR_PUSH      = 3'd3;
    localparam logic [2:0] ERR_AFTER_END = 3'd4;

    typedef struct packed {
        logic        deliver;
        logic        is_copy;
        logic [15:0] rd_addr;
        logic [7:0]  fill_byte;
        logic [15:0] pos;
        logic        need_byte;
        logic        done_res;
        logic [2:0]  error_code;
    } lzcf_step_t;

    typedef struct packed {
        logic        out_valid;
        logic [7:0]  out_byte;
        logic [15:0] out_pos;
        logic        need_byte;
        logic        done_res;
        logic [2:0]  error_code;
    } lzcf_res_t;

    function automatic logic [2:0] sticky_err(input logic [2:0] cur, input logic [2:0] code);
        sticky_err = (cur == ERR_NONE) ? code : cur;
    endfunction

endpackage

[hw/rtl/lzcf_req_if.sv]
// Request channel: valid/ready handshake with one request beat.
// Depends on nothing but the bit widths of the request fields.
interface lzcf_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] in_byte;

    modport source (output valid, output req_type, output in_byte, input ready);
    modport sink (input valid, input req_type, input in_byte, output ready);
endinterface

[hw/rtl/lzcf_res_if.sv]
// Result channel: valid/ready handshake with one result beat per request.
// Depends on nothing but the bit widths of the result fields.
interface lzcf_res_if;
    logic        valid;
    logic        ready;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic [15:0] out_pos;
    logic        need_byte;
    logic        done_res;
    logic [2:0]  error_code;

    modport source (output valid, output out_valid, output out_byte, output out_pos,
                    output need_byte, output done_res, output error_code, input ready);
    modport sink (input valid, input out_valid, input out_byte, input out_pos,
                  input need_byte, input done_res, input error_code, output ready);
endinterface

[hw/rtl/lzcf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; read during write at the same address returns the old data.
module lzcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/lzcf_ctrl.sv]
// Command parser and decoder state: updates the state on accepted push, pull and restart beats.
// Depends on lzcf_pkg; hands a step descriptor to the top level's RAM pipeline.
module lzcf_ctrl
    import lzcf_pkg::*;
#(
    parameter int HISTORY_BYTES = HISTORY_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       take,
    input  logic [1:0] req_type,
    input  logic [7:0] in_byte,
    output lzcf_step_t step
);

    typedef enum logic [3:0] {
        PH_CMD      = 4'd0,
        PH_SHORT_P  = 4'd1,
        PH_CNT0     = 4'd2,
        PH_CNT1     = 4'd3,
        PH_FILL_V   = 4'd4,
        PH_OFF0     = 4'd5,
        PH_OFF1     = 4'd6,
        PH_LIT_WAIT = 4'd7,
        PH_LIT_OUT  = 4'd8,
        PH_COPY_OUT = 4'd9,
        PH_FILL_OUT = 4'd10
    } phase_t;

    typedef enum logic [2:0] {
        KIND_SHORT = 3'd0,
        KIND_LIT   = 3'd1,
        KIND_MED   = 3'd2,
        KIND_FILL  = 3'd3,
        KIND_LONG  = 3'd4
    } kind_t;

    localparam logic [WPOS_W-1:0] FULL_POS = WPOS_W'(HISTORY_BYTES);

    phase_t              phase_reg, phase_next;
    kind_t               kind_reg, kind_next;
    logic [WPOS_W-1:0]   wpos_reg, wpos_next;
    logic [15:0]         remaining_reg, remaining_next;
    logic [15:0]         source_reg, source_next;
    logic [7:0]          fill_reg, fill_next;
    logic [7:0]          partial_reg, partial_next;
    logic                finished_reg, finished_next;
    logic [2:0]          err_reg, err_next;
    logic                mode_reg;

    logic [11:0]         short_dist;
    logic [15:0]         offset;
    logic [WPOS_W-1:0]   copy_src;
    logic                copy_ok;
    logic                out_phase;

    always_comb
    begin
        short_dist = {partial_reg[3:0], in_byte};
        offset     = {in_byte, partial_reg};
        if (phase_reg == PH_SHORT_P)
        begin
            copy_src = wpos_reg - WPOS_W'(short_dist);
            copy_ok  = (short_dist != 12'd0) && (WPOS_W'(short_dist) <= wpos_reg);
        end
        else if (mode_reg)
        begin
            copy_src = wpos_reg - WPOS_W'(offset);
            copy_ok  = (offset != 16'd0) && (WPOS_W'(offset) <= wpos_reg);
        end
        else
        begin
            copy_src = WPOS_W'(offset);
            copy_ok  = 1'b1;
        end
        copy_ok = copy_ok && (copy_src < wpos_reg);
        out_phase = (phase_reg == PH_LIT_OUT) || (phase_reg == PH_COPY_OUT)
                    || (phase_reg == PH_FILL_OUT);
    end

    always_comb
    begin
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        wpos_next      = wpos_reg;
        remaining_next = remaining_reg;
        source_next    = source_reg;
        fill_next      = fill_reg;
        partial_next   = partial_reg;
        finished_next  = finished_reg;
        err_next       = err_reg;
        step           = '0;

        if (take)
        begin
            case (req_type)
                REQ_RESTART:
                begin
                    phase_next     = PH_CMD;
                    kind_next      = KIND_SHORT;
                    wpos_next      = '0;
                    remaining_next = '0;
                    source_next    = '0;
                    fill_next      = '0;
                    partial_next   = '0;
                    finished_next  = 1'b0;
                    err_next       = ERR_NONE;
                end
                REQ_PUSH:
                begin
                    if (finished_reg)
                    begin
                        err_next = sticky_err(err_reg, ERR_AFTER_END);
                    end
                    else if (out_phase)
                    begin
                        err_next = sticky_err(err_reg, ERR_PUSH);
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_CMD:
                            begin
                                if (!in_byte[7])
                                begin
                                    kind_next      = KIND_SHORT;
                                    remaining_next = 16'(in_byte[6:4]) + 16'd3;
                                    partial_next   = {4'd0, in_byte[3:0]};
                                    phase_next     = PH_SHORT_P;
                                end
                                else if (!in_byte[6])
                                begin
                                    kind_next      = KIND_LIT;
                                    remaining_next = 16'(in_byte[5:0]);
                                    if (in_byte[5:0] == 6'd0)
                                    begin
                                        finished_next = 1'b1;
                                        phase_next    = PH_CMD;
                                    end
                                    else
                                    begin
                                        phase_next = PH_LIT_WAIT;
                                    end
                                end
                                else if (in_byte[5:0] < 6'h3e)
                                begin
                                    kind_next      = KIND_MED;
                                    remaining_next = 16'(in_byte[5:0]) + 16'd3;
                                    phase_next     = PH_OFF0;
                                end
                                else
                                begin
                                    kind_next  = (in_byte[5:0] == 6'h3e) ? KIND_FILL : KIND_LONG;
                                    phase_next = PH_CNT0;
                                end
                            end
                            PH_SHORT_P, PH_OFF1:
                            begin
                                if (phase_reg == PH_OFF1 && remaining_reg == 16'd0)
                                begin
                                    phase_next = PH_CMD;
                                end
                                else if (copy_ok)
                                begin
                                    source_next = copy_src[15:0];
                                    phase_next  = PH_COPY_OUT;
                                end
                                else
                                begin
                                    err_next       = sticky_err(err_reg, ERR_BAD_SRC);
                                    phase_next     = PH_CMD;
                                    remaining_next = '0;
                                end
                            end
                            PH_CNT0, PH_OFF0:
                            begin
                                partial_next = in_byte;
                                phase_next   = (phase_reg == PH_CNT0) ? PH_CNT1 : PH_OFF1;
                            end
                            PH_CNT1:
                            begin
                                remaining_next = {in_byte, partial_reg};
                                phase_next     = (kind_reg == KIND_FILL) ? PH_FILL_V : PH_OFF0;
                            end
                            PH_FILL_V:
                            begin
                                fill_next  = in_byte;
                                phase_next = (remaining_reg == 16'd0) ? PH_CMD : PH_FILL_OUT;
                            end
                            PH_LIT_WAIT:
                            begin
                                fill_next  = in_byte;
                                phase_next = PH_LIT_OUT;
                            end
                            default:
                            begin
                                phase_next = PH_CMD;
                            end
                        endcase
                    end
                end
                REQ_PULL:
                begin
                    if (!finished_reg && out_phase)
                    begin
                        if (wpos_reg >= FULL_POS)
                        begin
                            err_next       = sticky_err(err_reg, ERR_FULL);
                            phase_next     = PH_CMD;
                            remaining_next = '0;
                        end
                        else
                        begin
                            step.deliver   = 1'b1;
                            step.is_copy   = (phase_reg == PH_COPY_OUT);
                            step.rd_addr   = source_reg;
                            step.fill_byte = fill_reg;
                            step.pos       = wpos_reg[15:0];
                            if (phase_reg == PH_COPY_OUT)
                            begin
                                source_next = source_reg + 16'd1;
                            end
                            wpos_next      = wpos_reg + WPOS_W'(1);
                            remaining_next = remaining_reg - 16'd1;
                            if (phase_reg == PH_LIT_OUT)
                            begin
                                phase_next = (remaining_next == 16'd0) ? PH_CMD : PH_LIT_WAIT;
                            end
                            else if (remaining_next == 16'd0)
                            begin
                                phase_next = PH_CMD;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        step.need_byte  = !finished_next && (phase_next != PH_LIT_OUT)
                          && (phase_next != PH_COPY_OUT) && (phase_next != PH_FILL_OUT);
        step.done_res   = finished_next;
        step.error_code = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CMD;
            kind_reg      <= KIND_SHORT;
            wpos_reg      <= '0;
            remaining_reg <= '0;
            source_reg    <= '0;
            fill_reg      <= '0;
            partial_reg   <= '0;
            finished_reg  <= 1'b0;
            err_reg       <= ERR_NONE;
            mode_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            wpos_reg      <= wpos_next;
            remaining_reg <= remaining_next;
            source_reg    <= source_next;
            fill_reg      <= fill_next;
            partial_reg   <= partial_next;
            finished_reg  <= finished_next;
            err_reg       <= err_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
        end
    end

endmodule

[hw/rtl/lz_copy_fill_decoder.sv]
// Copy/fill stream decoder top level: request/result channels and history RAM.
// Depends on lzcf_pkg, lzcf_req_if, lzcf_res_if, lzcf_ram and lzcf_ctrl.
//
// Takes one request beat per cycle unless a stalled result holds the read
// stage, and returns exactly one result beat per request, via the read stage
// and result registers. A pull of a copied byte reads the history RAM (one
// read port) at acceptance; the byte is written back at its image position as
// the result leaves the read stage, and a read of the entry written in the
// same cycle is forwarded. The result register lets the next request enter
// while a finished result waits. History needs no clearing pass after reset.
module lz_copy_fill_decoder
    import lzcf_pkg::*;
#(
    parameter int HISTORY_BYTES = HISTORY_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    lzcf_req_if.sink   req,
    lzcf_res_if.source res
);

    localparam int AW = $clog2(HISTORY_BYTES);

    lzcf_step_t  step;
    logic        take;
    logic        p1_move;

    logic        p1_valid_reg;
    lzcf_step_t  p1_step_reg;
    logic        p1_fwd_hit_reg;
    logic [7:0]  p1_fwd_data_reg;
    logic [7:0]  p1_byte;

    logic        out_valid_reg;
    lzcf_res_t   out_reg, out_next;

    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    logic        ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]  ram_rdata;
    logic        fwd_hit_next;

    assign p1_move   = p1_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !p1_valid_reg || p1_move;
    assign take      = req.valid && req.ready;

    lzcf_ctrl #(
        .HISTORY_BYTES (HISTORY_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .take      (take),
        .req_type  (req.req_type),
        .in_byte   (req.in_byte),
        .step      (step)
    );

    always_comb
    begin
        if (!p1_step_reg.deliver)
        begin
            p1_byte = 8'd0;
        end
        else if (p1_step_reg.is_copy)
        begin
            p1_byte = p1_fwd_hit_reg ? p1_fwd_data_reg : ram_rdata;
        end
        else
        begin
            p1_byte = p1_step_reg.fill_byte;
        end
    end

    assign ram_we       = p1_move && p1_step_reg.deliver;
    assign ram_waddr    = p1_step_reg.pos[AW-1:0];
    assign ram_re       = take && step.is_copy;
    assign ram_raddr    = step.rd_addr[AW-1:0];
    assign fwd_hit_next = ram_we && ram_re && (ram_waddr == ram_raddr);

    lzcf_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_BYTES)
    ) u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (p1_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        out_next.out_valid  = p1_step_reg.deliver;
        out_next.out_byte   = p1_byte;
        out_next.out_pos    = p1_step_reg.deliver ? p1_step_reg.pos : 16'd0;
        out_next.need_byte  = p1_step_reg.need_byte;
        out_next.done_res   = p1_step_reg.done_res;
        out_next.error_code = p1_step_reg.error_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (p1_move)
            begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            p1_step_reg     <= step;
            p1_fwd_hit_reg  <= fwd_hit_next;
            p1_fwd_data_reg <= p1_byte;
        end
        if (p1_move)
        begin
            out_reg <= out_next;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.out_valid  = out_reg.out_valid;
    assign res.out_byte   = out_reg.out_byte;
    assign res.out_pos    = out_reg.out_pos;
    assign res.need_byte  = out_reg.need_byte;
    assign res.done_res   = out_reg.done_res;
    assign res.error_code = out_reg.error_code;

    a_fwd_only_copy: assert property (@(posedge clk) disable iff (!rst_n)
        (p1_valid_reg && p1_fwd_hit_reg) |-> p1_step_reg.is_copy)
        else $error("forward hit on a non-copy beat");

    a_no_byte_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.out_valid) |-> !res.done_res)
        else $error("decoded byte after end of image");

    a_no_byte_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.out_valid) |-> (res.error_code != ERR_FULL))
        else $error("decoded byte after output full");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.out_valid) |-> (32'(res.out_pos) < HISTORY_BYTES))
        else $error("decoded byte outside history");

endmodule
